// ===== rtl/core/tcf_pkg.sv =====
// Shared types and constants for the touch calibrate and filter core.
// Used by tcf_div, tcf_ctl and touch_calibrate_and_filter_core.
package tcf_pkg;

  localparam int SPAN_W     = 12;
  localparam int SCR_W      = 8;
  localparam int BTN_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [1:0] KIND_BTN = 2'd0;
  localparam logic [1:0] KIND_REL = 2'd1;
  localparam logic [1:0] KIND_POS = 2'd2;

  localparam logic [SCR_W-1:0] TOP_X     = 8'd255;
  localparam logic [SCR_W-1:0] TOP_Y     = 8'd191;
  localparam logic [SCR_W:0]   NEAR_DIST = 9'd6;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_X_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_X_SPAN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_SPAN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_X_ORG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_Y_ORG   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_X_SPAN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_Y_SPAN  = 3'd7;

  typedef struct packed {
    logic [SPAN_W-1:0] raw_x_low;
    logic [SPAN_W-1:0] raw_y_low;
    logic [SPAN_W-1:0] raw_x_span;
    logic [SPAN_W-1:0] raw_y_span;
    logic [SCR_W-1:0]  scr_x_org;
    logic [SCR_W-1:0]  scr_y_org;
    logic [SCR_W-1:0]  scr_x_span;
    logic [SCR_W-1:0]  scr_y_span;
  } cal_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/tcf_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on tcf_pkg for widths and the status struct.
module tcf_div #(
  parameter int DIV_W = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DIV_W-1:0]          dividend,
  input  logic [tcf_pkg::SPAN_W-1:0] divisor,
  output logic [DIV_W-1:0]          quotient,
  output tcf_pkg::div_stat_t        stat
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]           quo_r;
  logic [tcf_pkg::SPAN_W-1:0] rem_r;
  logic [tcf_pkg::SPAN_W-1:0] dsr_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [tcf_pkg::SPAN_W:0]   sh;
  logic                       ge;
  logic [tcf_pkg::SPAN_W:0]   sub;

  assign sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge  = sh >= {1'b0, dsr_r};
  assign sub = sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? sub[tcf_pkg::SPAN_W-1:0] : sh[tcf_pkg::SPAN_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/core/tcf_ctl.sv =====
// Sequencer: button tracking, per-axis mapping through the shared divider,
// jitter filter and the output register. Depends on tcf_pkg and tcf_div.
module tcf_ctl #(
  parameter int RELEASE_BIT = 6,
  parameter int RAW_BITS    = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcf_pkg::cal_cfg_t          cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tcf_pkg::BTN_W-1:0]  in_button_word,
  input  logic [RAW_BITS-1:0]        in_raw_x,
  input  logic [RAW_BITS-1:0]        in_raw_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_message_kind,
  output logic [tcf_pkg::BTN_W-1:0]  out_buttons_out,
  output logic [tcf_pkg::SCR_W-1:0]  out_screen_x,
  output logic [tcf_pkg::SCR_W-1:0]  out_screen_y,
  output logic                       out_last_of_tick
);

  localparam int DW = (RAW_BITS > tcf_pkg::SPAN_W) ? RAW_BITS : tcf_pkg::SPAN_W;
  localparam int MW = DW + tcf_pkg::SCR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FILT = 3'd5;
  localparam logic [2:0] S_EBTN = 3'd6;
  localparam logic [2:0] S_ESEC = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic                        axis_r;
  logic [tcf_pkg::BTN_W-1:0]   prev_btn_r;
  logic [tcf_pkg::SCR_W-1:0]   prev_x_r, prev_y_r;
  logic                        have_prev_r;
  logic [tcf_pkg::BTN_W-1:0]   btn_r;
  logic [RAW_BITS-1:0]         raw_x_r, raw_y_r;
  logic                        chg_r, rel_r, sec_r;
  logic [MW-1:0]               prod_r;
  logic                        neg_r;
  logic [tcf_pkg::SCR_W-1:0]   x_r, y_r;

  logic                        out_valid_r;
  logic [1:0]                  out_kind_r;
  logic [tcf_pkg::BTN_W-1:0]   out_btn_r;
  logic [tcf_pkg::SCR_W-1:0]   out_x_r, out_y_r;
  logic                        out_last_r;

  logic                        accept, slot_free;
  logic                        in_rel, in_chg;
  logic [RAW_BITS-1:0]         raw_sel;
  logic [tcf_pkg::SPAN_W-1:0]  low_sel, rspan_sel;
  logic [tcf_pkg::SCR_W-1:0]   sspan_sel, org_sel, top_sel;
  logic [DW:0]                 diff;
  logic [DW:0]                 diff_abs;
  logic [MW-1:0]               prod;
  logic [MW-1:0]               quo;
  tcf_pkg::div_stat_t          div_stat;
  logic [MW:0]                 q_s;
  logic [MW+1:0]               v;
  logic [tcf_pkg::SCR_W-1:0]   v_clamp;
  logic                        near_x, near_y, pos;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_rel    = in_button_word[RELEASE_BIT];
  assign in_chg    = in_button_word != prev_btn_r;

  assign raw_sel   = axis_r ? raw_y_r : raw_x_r;
  assign low_sel   = axis_r ? cfg.raw_y_low : cfg.raw_x_low;
  assign rspan_sel = axis_r ? cfg.raw_y_span : cfg.raw_x_span;
  assign sspan_sel = axis_r ? cfg.scr_y_span : cfg.scr_x_span;
  assign org_sel   = axis_r ? cfg.scr_y_org : cfg.scr_x_org;
  assign top_sel   = axis_r ? tcf_pkg::TOP_Y : tcf_pkg::TOP_X;

  assign diff     = {1'b0, DW'(raw_sel)} - {1'b0, DW'(low_sel)};
  assign diff_abs = diff[DW] ? (~diff + 1'b1) : diff;
  assign prod     = MW'(diff_abs[DW-1:0]) * MW'(sspan_sel);

  tcf_div #(.DIV_W(MW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_LOAD),
    .dividend (prod_r),
    .divisor  (rspan_sel),
    .quotient (quo),
    .stat     (div_stat)
  );

  always_comb begin
    if (rspan_sel == '0) begin
      q_s = '0;
    end else if (neg_r) begin
      q_s = ~{1'b0, quo} + 1'b1;
    end else begin
      q_s = {1'b0, quo};
    end
    v = {q_s[MW], q_s} + (MW+2)'(org_sel);
    if (v[MW+1]) begin
      v_clamp = '0;
    end else if (v[MW:0] > (MW+1)'(top_sel)) begin
      v_clamp = top_sel;
    end else begin
      v_clamp = v[tcf_pkg::SCR_W-1:0];
    end
  end

  assign near_x = ({1'b0, prev_x_r} + tcf_pkg::NEAR_DIST > {1'b0, x_r}) &&
                  ({1'b0, prev_x_r} < {1'b0, x_r} + tcf_pkg::NEAR_DIST);
  assign near_y = ({1'b0, prev_y_r} + tcf_pkg::NEAR_DIST > {1'b0, y_r}) &&
                  ({1'b0, prev_y_r} < {1'b0, y_r} + tcf_pkg::NEAR_DIST);
  assign pos    = have_prev_r && near_x && near_y;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_rel) begin
            state_nxt = in_chg ? S_EBTN : S_ESEC;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_stat.done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD:  state_nxt = axis_r ? S_FILT : S_MUL;
      S_FILT: begin
        if (chg_r) begin
          state_nxt = S_EBTN;
        end else begin
          state_nxt = pos ? S_ESEC : S_IDLE;
        end
      end
      S_EBTN: begin
        if (slot_free) begin
          state_nxt = sec_r ? S_ESEC : S_IDLE;
        end
      end
      S_ESEC: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      prev_btn_r  <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        prev_btn_r <= in_button_word;
        axis_r     <= 1'b0;
        if (in_rel) begin
          have_prev_r <= 1'b0;
        end
      end
      if (state_r == S_ADD) begin
        axis_r <= 1'b1;
      end
      if (state_r == S_FILT) begin
        prev_x_r    <= x_r;
        prev_y_r    <= y_r;
        have_prev_r <= 1'b1;
      end
      if ((state_r == S_EBTN || state_r == S_ESEC) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      btn_r   <= in_button_word;
      raw_x_r <= in_raw_x;
      raw_y_r <= in_raw_y;
      chg_r   <= in_chg;
      rel_r   <= in_rel;
      sec_r   <= in_rel;
    end
    if (state_r == S_MUL) begin
      prod_r <= prod;
      neg_r  <= diff[DW];
    end
    if (state_r == S_ADD) begin
      if (axis_r) begin
        y_r <= v_clamp;
      end else begin
        x_r <= v_clamp;
      end
    end
    if (state_r == S_FILT) begin
      sec_r <= pos;
    end
    if (state_r == S_EBTN && slot_free) begin
      out_kind_r <= tcf_pkg::KIND_BTN;
      out_btn_r  <= btn_r;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_last_r <= !sec_r;
    end
    if (state_r == S_ESEC && slot_free) begin
      out_kind_r <= rel_r ? tcf_pkg::KIND_REL : tcf_pkg::KIND_POS;
      out_btn_r  <= '0;
      out_x_r    <= rel_r ? '0 : x_r;
      out_y_r    <= rel_r ? '0 : y_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_message_kind = out_kind_r;
  assign out_buttons_out  = out_btn_r;
  assign out_screen_x     = out_x_r;
  assign out_screen_y     = out_y_r;
  assign out_last_of_tick = out_last_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted item did not start the sequencer");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_WAIT)
    else $error("divider finished outside the wait step");

  a_release_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == tcf_pkg::KIND_REL |-> out_last_r)
    else $error("release message not marked last of tick");

  a_filter_primes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILT |=> have_prev_r)
    else $error("last point not held after filter step");

endmodule

// ===== rtl/core/touch_calibrate_and_filter_core.sv =====
// Touch calibrate and filter core: calibration registers and sequencer; needs tcf_pkg, tcf_ctl.
// Other ticks: the serial divider, shared by both axes, maps the x axis and then the y axis,
// followed by the filter step and one output step per message.
// Release ticks skip the divider and go straight to the output steps, one per message.
// One item at a time; in_stall is high while a tick is being worked.
// Synchronous reset restores calibration defaults and the last point (0,0).
module touch_calibrate_and_filter_core #(
  parameter int RELEASE_BIT = 6,
  parameter int RAW_BITS    = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tcf_pkg::BTN_W-1:0]      in_button_word,
  input  logic [RAW_BITS-1:0]            in_raw_x,
  input  logic [RAW_BITS-1:0]            in_raw_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_message_kind,
  output logic [tcf_pkg::BTN_W-1:0]      out_buttons_out,
  output logic [tcf_pkg::SCR_W-1:0]      out_screen_x,
  output logic [tcf_pkg::SCR_W-1:0]      out_screen_y,
  output logic                           out_last_of_tick,
  input  logic                           cfg_we,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tcf_pkg::cal_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.raw_x_low  <= '0;
      cfg_r.raw_y_low  <= '0;
      cfg_r.raw_x_span <= 12'd4095;
      cfg_r.raw_y_span <= 12'd4095;
      cfg_r.scr_x_org  <= '0;
      cfg_r.scr_y_org  <= '0;
      cfg_r.scr_x_span <= tcf_pkg::TOP_X;
      cfg_r.scr_y_span <= tcf_pkg::TOP_Y;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcf_pkg::REG_RAW_X_LOW:  cfg_r.raw_x_low  <= cfg_wdata;
        tcf_pkg::REG_RAW_Y_LOW:  cfg_r.raw_y_low  <= cfg_wdata;
        tcf_pkg::REG_RAW_X_SPAN: cfg_r.raw_x_span <= cfg_wdata;
        tcf_pkg::REG_RAW_Y_SPAN: cfg_r.raw_y_span <= cfg_wdata;
        tcf_pkg::REG_SCR_X_ORG:  cfg_r.scr_x_org  <= cfg_wdata[tcf_pkg::SCR_W-1:0];
        tcf_pkg::REG_SCR_Y_ORG:  cfg_r.scr_y_org  <= cfg_wdata[tcf_pkg::SCR_W-1:0];
        tcf_pkg::REG_SCR_X_SPAN: cfg_r.scr_x_span <= cfg_wdata[tcf_pkg::SCR_W-1:0];
        tcf_pkg::REG_SCR_Y_SPAN: cfg_r.scr_y_span <= cfg_wdata[tcf_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  tcf_ctl #(
    .RELEASE_BIT (RELEASE_BIT),
    .RAW_BITS    (RAW_BITS)
  ) u_ctl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_button_word   (in_button_word),
    .in_raw_x         (in_raw_x),
    .in_raw_y         (in_raw_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_message_kind (out_message_kind),
    .out_buttons_out  (out_buttons_out),
    .out_screen_x     (out_screen_x),
    .out_screen_y     (out_screen_y),
    .out_last_of_tick (out_last_of_tick)
  );

endmodule
